// ===== sv/ptsd_pkg.sv =====
// Package for the point-to-triangle squared distance engine.
// Shared constants, region codes, result record and width helpers.
// No dependencies.
package ptsd_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int SQ_WIDTH    = 50;
    localparam int PT_WIDTH    = 32;
    localparam int PARAM_WIDTH = 17;

    // Depth of the queue between the classifier and the solver
    localparam int MID_DEPTH = 8;

    typedef enum logic [2:0] {
        RGN_INSIDE  = 3'd0,
        RGN_HYPOT   = 3'd1,
        RGN_HYPOT_T = 3'd2,
        RGN_EDGE_T  = 3'd3,
        RGN_VERTEX  = 3'd4,
        RGN_EDGE_S  = 3'd5,
        RGN_HYPOT_S = 3'd6
    } region_t;

    typedef struct packed {
        logic [SQ_WIDTH-1:0]      sq_distance;
        logic [2:0][PT_WIDTH-1:0] closest;
        logic [PARAM_WIDTH-1:0]   param_s;
        logic [PARAM_WIDTH-1:0]   param_t;
        region_t                  region;
        logic                     degenerate;
    } result_t;

    // Edge and offset vectors: one bit over the coordinates
    function automatic int edge_width(input int cw);
        return cw + 1;
    endfunction

    // Dot products of edge vectors
    function automatic int dot_width(input int cw);
        return 2 * edge_width(cw) + 2;
    endfunction

    // Products of dot products (det, s and t numerators)
    function automatic int wide_width(input int cw);
        return 2 * dot_width(cw) + 2;
    endfunction

    // Width of one classified transaction passed to the solver
    function automatic int req_width(input int cw);
        return 3 * cw + 9 * edge_width(cw) + 4 * wide_width(cw) + 3 + 1 + 2;
    endfunction

    // Result queue depth covers the solver latency
    function automatic int out_depth(input int f);
        return 2 ** $clog2(f + 8);
    endfunction

endpackage

// ===== sv/ptsd_fifo.sv =====
// Small synchronous queue built from a register file.
// Depends on nothing; depth must be a power of two.
module ptsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_pop;

    assign empty  = (count_reg == '0);
    assign head   = mem[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/ptsd_front.sv =====
// Classifier: edge vectors, dot products, determinant and region selection.
// Depends on ptsd_pkg. Five register stages, one transaction per cycle.
module ptsd_front #(
    parameter int CW = ptsd_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [2:0][CW-1:0]                   v1,
    input  logic [2:0][CW-1:0]                   v2,
    input  logic [2:0][CW-1:0]                   v3,
    input  logic [2:0][CW-1:0]                   pt,
    output logic                                 out_valid,
    output logic [ptsd_pkg::req_width(CW)-1:0]   out_req
);

    import ptsd_pkg::*;

    localparam int EW  = edge_width(CW);
    localparam int AW  = dot_width(CW);
    localparam int AW1 = AW + 1;
    localparam int AW2 = AW + 2;
    localparam int WW  = wide_width(CW);

    typedef struct packed {
        logic [2:0][CW-1:0] v1;
        logic [2:0][EW-1:0] e0;
        logic [2:0][EW-1:0] e1;
        logic [2:0][EW-1:0] d;
    } geom_t;

    typedef struct packed {
        logic signed [WW-1:0] num;
        logic signed [WW-1:0] den;
    } div_req_t;

    typedef struct packed {
        geom_t    geom;
        region_t  region;
        logic     deg;
        div_req_t s_req;
        div_req_t t_req;
        logic     s_from_t;
        logic     t_from_s;
    } req_t;

    typedef struct packed {
        logic signed [AW-1:0] a00;
        logic signed [AW-1:0] a01;
        logic signed [AW-1:0] a11;
        logic signed [AW-1:0] b0;
        logic signed [AW-1:0] b1;
    } dots_t;

    // Parameter along one edge from V1 as a divide request
    function automatic div_req_t edge_req(input logic signed [AW-1:0] b,
                                          input logic signed [AW-1:0] a);
        div_req_t r;
        logic signed [AW1-1:0] nb;
        nb = -AW1'(b);
        r.num = '0;
        r.den = WW'(1);
        if (b >= 0)
        begin
            r.num = '0;
        end
        else if (nb >= AW1'(a))
        begin
            r.num = WW'(1);
        end
        else
        begin
            r.num = WW'(nb);
            r.den = WW'(a);
        end
        return r;
    endfunction

    logic [4:0] val_reg;

    geom_t g0_reg, g1_reg, g2_reg, g3_reg;
    geom_t g0_next;
    dots_t dots1_reg, dots2_reg, dots3_reg;
    dots_t dots1_next;

    logic signed [WW-1:0]  p_aa_reg, p_cc_reg, p_ab1_reg, p_cb0_reg, p_ab0_reg, p_db1_reg;
    logic signed [AW2-1:0] denom2_reg, denom3_reg;
    logic signed [WW-1:0]  det3_reg, sw3_reg, tw3_reg;
    logic signed [WW-1:0]  det_next;

    req_t req_reg;
    req_t req_next;

    // Stage 0: edge and offset vectors
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g0_next.v1[i] = v1[i];
            g0_next.e0[i] = EW'($signed(v2[i])) - EW'($signed(v1[i]));
            g0_next.e1[i] = EW'($signed(v3[i])) - EW'($signed(v1[i]));
            g0_next.d[i]  = EW'($signed(v1[i])) - EW'($signed(pt[i]));
        end
    end

    // Stage 1: dot products
    always_comb
    begin
        dots1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            dots1_next.a00 = dots1_next.a00
                + AW'($signed(g0_reg.e0[i])) * AW'($signed(g0_reg.e0[i]));
            dots1_next.a01 = dots1_next.a01
                + AW'($signed(g0_reg.e0[i])) * AW'($signed(g0_reg.e1[i]));
            dots1_next.a11 = dots1_next.a11
                + AW'($signed(g0_reg.e1[i])) * AW'($signed(g0_reg.e1[i]));
            dots1_next.b0 = dots1_next.b0
                + AW'($signed(g0_reg.d[i])) * AW'($signed(g0_reg.e0[i]));
            dots1_next.b1 = dots1_next.b1
                + AW'($signed(g0_reg.d[i])) * AW'($signed(g0_reg.e1[i]));
        end
    end

    // Stage 3 arithmetic: determinant magnitude
    always_comb
    begin
        det_next = p_aa_reg - p_cc_reg;
        if (det_next < 0)
        begin
            det_next = -det_next;
        end
    end

    // Stage 4: sort into a region and form the divide requests
    always_comb
    begin
        logic signed [WW:0]    stw;
        logic signed [AW1-1:0] tmp0;
        logic signed [AW1-1:0] tmp1;
        logic signed [AW2-1:0] numer;
        div_req_t              zero_req;

        zero_req.num = '0;
        zero_req.den = WW'(1);
        stw   = (WW + 1)'(sw3_reg) + (WW + 1)'(tw3_reg);
        tmp0  = '0;
        tmp1  = '0;
        numer = '0;

        req_next.geom     = g3_reg;
        req_next.region   = RGN_INSIDE;
        req_next.deg      = 1'b0;
        req_next.s_req    = zero_req;
        req_next.t_req    = zero_req;
        req_next.s_from_t = 1'b0;
        req_next.t_from_s = 1'b0;

        if (det3_reg == '0)
        begin
            req_next.deg = 1'b1;
        end
        else if (stw <= (WW + 1)'(det3_reg))
        begin
            if (sw3_reg < 0)
            begin
                if (tw3_reg < 0)
                begin
                    req_next.region = RGN_VERTEX;
                    if (dots3_reg.b0 < 0)
                    begin
                        req_next.s_req = edge_req(dots3_reg.b0, dots3_reg.a00);
                    end
                    else
                    begin
                        req_next.t_req = edge_req(dots3_reg.b1, dots3_reg.a11);
                    end
                end
                else
                begin
                    req_next.region = RGN_EDGE_T;
                    req_next.t_req  = edge_req(dots3_reg.b1, dots3_reg.a11);
                end
            end
            else if (tw3_reg < 0)
            begin
                req_next.region = RGN_EDGE_S;
                req_next.s_req  = edge_req(dots3_reg.b0, dots3_reg.a00);
            end
            else
            begin
                req_next.region    = RGN_INSIDE;
                req_next.s_req.num = sw3_reg;
                req_next.s_req.den = det3_reg;
                req_next.t_req.num = tw3_reg;
                req_next.t_req.den = det3_reg;
            end
        end
        else if (sw3_reg < 0)
        begin
            req_next.region = RGN_HYPOT_T;
            tmp0 = AW1'(dots3_reg.a01) + AW1'(dots3_reg.b0);
            tmp1 = AW1'(dots3_reg.a11) + AW1'(dots3_reg.b1);
            if (tmp1 > tmp0)
            begin
                numer              = AW2'(tmp1) - AW2'(tmp0);
                req_next.s_req.num = WW'(numer);
                req_next.s_req.den = WW'(denom3_reg);
                req_next.t_from_s  = 1'b1;
            end
            else
            begin
                req_next.t_req = edge_req(dots3_reg.b1, dots3_reg.a11);
            end
        end
        else if (tw3_reg < 0)
        begin
            req_next.region = RGN_HYPOT_S;
            tmp0 = AW1'(dots3_reg.a01) + AW1'(dots3_reg.b1);
            tmp1 = AW1'(dots3_reg.a00) + AW1'(dots3_reg.b0);
            if (tmp1 > tmp0)
            begin
                numer              = AW2'(tmp1) - AW2'(tmp0);
                req_next.t_req.num = WW'(numer);
                req_next.t_req.den = WW'(denom3_reg);
                req_next.s_from_t  = 1'b1;
            end
            else
            begin
                req_next.s_req = edge_req(dots3_reg.b0, dots3_reg.a00);
            end
        end
        else
        begin
            req_next.region   = RGN_HYPOT;
            req_next.t_from_s = 1'b1;
            numer = AW2'(dots3_reg.a11) + AW2'(dots3_reg.b1)
                  - AW2'(dots3_reg.a01) - AW2'(dots3_reg.b0);
            if (numer > 0)
            begin
                req_next.s_req.num = WW'(numer);
                req_next.s_req.den = WW'(denom3_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            val_reg <= {val_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        g0_reg <= g0_next;

        g1_reg    <= g0_reg;
        dots1_reg <= dots1_next;

        g2_reg     <= g1_reg;
        dots2_reg  <= dots1_reg;
        p_aa_reg   <= WW'(dots1_reg.a00) * WW'(dots1_reg.a11);
        p_cc_reg   <= WW'(dots1_reg.a01) * WW'(dots1_reg.a01);
        p_ab1_reg  <= WW'(dots1_reg.a01) * WW'(dots1_reg.b1);
        p_cb0_reg  <= WW'(dots1_reg.a11) * WW'(dots1_reg.b0);
        p_ab0_reg  <= WW'(dots1_reg.a01) * WW'(dots1_reg.b0);
        p_db1_reg  <= WW'(dots1_reg.a00) * WW'(dots1_reg.b1);
        denom2_reg <= AW2'(dots1_reg.a00) - AW2'(dots1_reg.a01)
                    - AW2'(dots1_reg.a01) + AW2'(dots1_reg.a11);

        g3_reg     <= g2_reg;
        dots3_reg  <= dots2_reg;
        denom3_reg <= denom2_reg;
        det3_reg   <= det_next;
        sw3_reg    <= p_ab1_reg - p_cb0_reg;
        tw3_reg    <= p_ab0_reg - p_db1_reg;

        req_reg <= req_next;
    end

    assign out_valid = val_reg[4];
    assign out_req   = req_reg;

endmodule

// ===== sv/ptsd_back.sv =====
// Solver: pipelined fraction dividers, closest point and squared distance.
// Depends on ptsd_pkg. FRAC_BITS + 6 register stages, one transaction per cycle.
module ptsd_back #(
    parameter int CW = ptsd_pkg::COORD_WIDTH_DEF,
    parameter int F  = ptsd_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [ptsd_pkg::req_width(CW)-1:0] in_req,
    output logic                               out_valid,
    output ptsd_pkg::result_t                  out_res
);

    import ptsd_pkg::*;

    localparam int EW   = edge_width(CW);
    localparam int WW   = wide_width(CW);
    localparam int Q    = F + 1;
    localparam int OW   = EW + Q + 2;
    localparam int DQ   = OW + 1;
    localparam int CXW  = (DQ > PT_WIDTH + 1) ? DQ : PT_WIDTH + 1;
    localparam int SPW  = 2 * DQ;
    localparam int SUMW = (SPW + 2 > SQ_WIDTH + F + 1) ? SPW + 2 : SQ_WIDTH + F + 1;
    localparam logic [Q-1:0] ONE_Q = {1'b1, {F{1'b0}}};

    typedef struct packed {
        logic [2:0][CW-1:0] v1;
        logic [2:0][EW-1:0] e0;
        logic [2:0][EW-1:0] e1;
        logic [2:0][EW-1:0] d;
    } geom_t;

    typedef struct packed {
        logic signed [WW-1:0] num;
        logic signed [WW-1:0] den;
    } div_req_t;

    typedef struct packed {
        geom_t    geom;
        region_t  region;
        logic     deg;
        div_req_t s_req;
        div_req_t t_req;
        logic     s_from_t;
        logic     t_from_s;
    } req_t;

    typedef struct packed {
        geom_t   geom;
        region_t region;
        logic    deg;
        logic    s_from_t;
        logic    t_from_s;
    } ctl_t;

    typedef struct packed {
        logic          zero;
        logic          one;
        logic [WW-1:0] rem;
        logic [WW-1:0] den;
        logic [F-1:0]  q;
    } chan_t;

    function automatic chan_t div_init(input div_req_t r);
        chan_t c;
        c.zero = (r.num < 0) || (r.den <= 0);
        c.one  = !c.zero && (r.num >= r.den);
        c.rem  = r.num;
        c.den  = r.den;
        c.q    = '0;
        return c;
    endfunction

    // One restoring step: one quotient bit
    function automatic chan_t div_step(input chan_t c);
        chan_t         n;
        logic [WW:0]   sh;
        n  = c;
        sh = {c.rem, 1'b0};
        if (sh >= {1'b0, c.den})
        begin
            n.rem = WW'(sh - {1'b0, c.den});
            n.q   = {c.q[F-2:0], 1'b1};
        end
        else
        begin
            n.rem = sh[WW-1:0];
            n.q   = {c.q[F-2:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic [Q-1:0] div_result(input chan_t c);
        logic [Q-1:0] r;
        if (c.zero)
        begin
            r = '0;
        end
        else if (c.one)
        begin
            r = ONE_Q;
        end
        else
        begin
            r = {1'b0, c.q};
        end
        return r;
    endfunction

    req_t req_in;
    assign req_in = in_req;

    logic [F:0] dval_reg;
    ctl_t       dctl_reg [F+1];
    chan_t      ds_reg   [F+1];
    chan_t      dt_reg   [F+1];

    logic         fval_reg, mval_reg, aval_reg, sval_reg, eval_reg;
    ctl_t         fctl_reg, mctl_reg;
    logic [Q-1:0] s_reg, t_reg, ms_reg, mt_reg;
    logic [Q-1:0] s_next, t_next;

    logic signed [OW-1:0] off_next [3];
    logic signed [OW-1:0] off_reg  [3];
    logic signed [DQ-1:0] dq_next  [3];
    logic signed [DQ-1:0] dq_reg   [3];
    logic [SPW-1:0]       sqp_reg  [3];

    result_t ares_next, ares_reg, sres_reg, res_reg, res_next;

    // Final parameters; where flagged, one is taken as the complement of the other
    always_comb
    begin
        logic [Q-1:0] sq;
        logic [Q-1:0] tq;
        sq = div_result(ds_reg[F]);
        tq = div_result(dt_reg[F]);
        s_next = dctl_reg[F].s_from_t ? ONE_Q - tq : sq;
        t_next = dctl_reg[F].t_from_s ? ONE_Q - sq : tq;
    end

    // Offset from V1 along both edges
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            off_next[i] = OW'($signed(fctl_reg.geom.e0[i])) * OW'($signed({1'b0, s_reg}))
                        + OW'($signed(fctl_reg.geom.e1[i])) * OW'($signed({1'b0, t_reg}));
        end
    end

    // Closest point with saturation, and offset from P
    always_comb
    begin
        logic signed [CXW-1:0] cx;
        ares_next             = '0;
        ares_next.param_s     = PARAM_WIDTH'(ms_reg);
        ares_next.param_t     = PARAM_WIDTH'(mt_reg);
        ares_next.region      = mctl_reg.region;
        ares_next.degenerate  = mctl_reg.deg;
        for (int i = 0; i < 3; i++)
        begin
            dq_next[i] = (DQ'($signed(mctl_reg.geom.d[i])) <<< F) + DQ'(off_reg[i]);
            cx = (CXW'($signed(mctl_reg.geom.v1[i])) <<< F) + CXW'(off_reg[i]);
            if (cx[CXW-1:PT_WIDTH-1] == '0 || cx[CXW-1:PT_WIDTH-1] == '1)
            begin
                ares_next.closest[i] = cx[PT_WIDTH-1:0];
            end
            else if (cx[CXW-1])
            begin
                ares_next.closest[i] = {1'b1, {(PT_WIDTH - 1){1'b0}}};
            end
            else
            begin
                ares_next.closest[i] = {1'b0, {(PT_WIDTH - 1){1'b1}}};
            end
        end
    end

    // Sum of squares, drop fraction bits, saturate
    always_comb
    begin
        logic [SUMW-1:0] sum;
        sum = SUMW'(sqp_reg[0]) + SUMW'(sqp_reg[1]) + SUMW'(sqp_reg[2]);
        res_next = sres_reg;
        if (|sum[SUMW-1:F+SQ_WIDTH])
        begin
            res_next.sq_distance = '1;
        end
        else
        begin
            res_next.sq_distance = sum[F+SQ_WIDTH-1:F];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dval_reg <= '0;
            fval_reg <= 1'b0;
            mval_reg <= 1'b0;
            aval_reg <= 1'b0;
            sval_reg <= 1'b0;
            eval_reg <= 1'b0;
        end
        else
        begin
            dval_reg <= {dval_reg[F-1:0], in_valid};
            fval_reg <= dval_reg[F];
            mval_reg <= fval_reg;
            aval_reg <= mval_reg;
            sval_reg <= aval_reg;
            eval_reg <= sval_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dctl_reg[0].geom     <= req_in.geom;
        dctl_reg[0].region   <= req_in.region;
        dctl_reg[0].deg      <= req_in.deg;
        dctl_reg[0].s_from_t <= req_in.s_from_t;
        dctl_reg[0].t_from_s <= req_in.t_from_s;
        ds_reg[0]            <= div_init(req_in.s_req);
        dt_reg[0]            <= div_init(req_in.t_req);
        for (int k = 0; k < F; k++)
        begin
            dctl_reg[k+1] <= dctl_reg[k];
            ds_reg[k+1]   <= div_step(ds_reg[k]);
            dt_reg[k+1]   <= div_step(dt_reg[k]);
        end

        fctl_reg <= dctl_reg[F];
        s_reg    <= s_next;
        t_reg    <= t_next;

        mctl_reg <= fctl_reg;
        ms_reg   <= s_reg;
        mt_reg   <= t_reg;
        for (int i = 0; i < 3; i++)
        begin
            off_reg[i] <= off_next[i];
        end

        ares_reg <= ares_next;
        for (int i = 0; i < 3; i++)
        begin
            dq_reg[i] <= dq_next[i];
        end

        sres_reg <= ares_reg;
        for (int i = 0; i < 3; i++)
        begin
            sqp_reg[i] <= SPW'(dq_reg[i]) * SPW'(dq_reg[i]);
        end

        res_reg <= res_next;
    end

    assign out_valid = eval_reg;
    assign out_res   = res_reg;

    a_param_sum: assert property (@(posedge clk) disable iff (!rst_n)
        fval_reg |-> ((Q + 1)'(s_reg) + (Q + 1)'(t_reg) <= (Q + 1)'(ONE_Q)))
        else $error("parameters sum above one");

    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        (eval_reg && res_reg.degenerate) |->
            (res_reg.param_s == '0 && res_reg.param_t == '0
             && res_reg.region == RGN_INSIDE))
        else $error("degenerate result with nonzero parameters");

endmodule

// ===== sv/point_triangle_sq_distance.sv =====
// Point-to-triangle squared distance engine. Each transaction carries three
// vertices and a query point as signed integers; the result gives the squared
// distance and closest point with FRAC_BITS fraction bits, the clamped edge
// parameters s and t in unsigned Q1.FRAC_BITS (truncated), the region 0..6 of
// the classic scheme and a flag for a zero determinant (then V1 is reported).
// Throughput is one query per clock while the consumer keeps popping and full
// stays low. A query passes through the classifier registers, the queue behind
// them and the solver registers, whose restoring dividers produce one quotient
// bit per stage and set the bulk of the latency. Both sides hold credit
// counters, so a stalled consumer backs up into the queues without dropping a
// transaction in flight.
module point_triangle_sq_distance #(
    parameter int COORD_WIDTH = ptsd_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ptsd_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic signed [COORD_WIDTH-1:0]           v1_x,
    input  logic signed [COORD_WIDTH-1:0]           v1_y,
    input  logic signed [COORD_WIDTH-1:0]           v1_z,
    input  logic signed [COORD_WIDTH-1:0]           v2_x,
    input  logic signed [COORD_WIDTH-1:0]           v2_y,
    input  logic signed [COORD_WIDTH-1:0]           v2_z,
    input  logic signed [COORD_WIDTH-1:0]           v3_x,
    input  logic signed [COORD_WIDTH-1:0]           v3_y,
    input  logic signed [COORD_WIDTH-1:0]           v3_z,
    input  logic signed [COORD_WIDTH-1:0]           point_x,
    input  logic signed [COORD_WIDTH-1:0]           point_y,
    input  logic signed [COORD_WIDTH-1:0]           point_z,
    output logic                                    empty,
    input  logic                                    pop,
    output logic [ptsd_pkg::SQ_WIDTH-1:0]           sq_distance,
    output logic signed [ptsd_pkg::PT_WIDTH-1:0]    closest_x,
    output logic signed [ptsd_pkg::PT_WIDTH-1:0]    closest_y,
    output logic signed [ptsd_pkg::PT_WIDTH-1:0]    closest_z,
    output logic [ptsd_pkg::PARAM_WIDTH-1:0]        param_s,
    output logic [ptsd_pkg::PARAM_WIDTH-1:0]        param_t,
    output logic [2:0]                              region,
    output logic                                    degenerate
);

    import ptsd_pkg::*;

    localparam int REQ_W     = req_width(COORD_WIDTH);
    localparam int RES_W     = $bits(result_t);
    localparam int OUT_DEPTH = out_depth(FRAC_BITS);
    localparam int MRW       = $clog2(MID_DEPTH + 1);
    localparam int ORW       = $clog2(OUT_DEPTH + 1);

    logic             in_take;
    logic             out_take;
    logic             front_valid;
    logic [REQ_W-1:0] front_req;
    logic             mid_empty;
    logic [REQ_W-1:0] mid_head;
    logic             mid_pop;
    logic             back_valid;
    result_t          back_res;
    logic [RES_W-1:0] out_head;
    result_t          res;

    // Credits: transactions in flight plus those already queued
    logic [MRW-1:0] mid_credit_reg;
    logic [MRW-1:0] mid_credit_next;
    logic [ORW-1:0] out_credit_reg;
    logic [ORW-1:0] out_credit_next;

    assign full     = (mid_credit_reg >= MRW'(MID_DEPTH));
    assign in_take  = push && !full;
    assign out_take = pop && !empty;

    // Advance a transaction into the solver only when the result queue has room
    assign mid_pop = !mid_empty && (out_credit_reg < ORW'(OUT_DEPTH));

    always_comb
    begin
        mid_credit_next = mid_credit_reg + MRW'(in_take) - MRW'(mid_pop);
        out_credit_next = out_credit_reg + ORW'(mid_pop) - ORW'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_credit_reg <= '0;
            out_credit_reg <= '0;
        end
        else
        begin
            mid_credit_reg <= mid_credit_next;
            out_credit_reg <= out_credit_next;
        end
    end

    ptsd_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_take),
        .v1        ({v1_z, v1_y, v1_x}),
        .v2        ({v2_z, v2_y, v2_x}),
        .v3        ({v3_z, v3_y, v3_x}),
        .pt        ({point_z, point_y, point_x}),
        .out_valid (front_valid),
        .out_req   (front_req)
    );

    ptsd_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_req),
        .pop       (mid_pop),
        .empty     (mid_empty),
        .head      (mid_head)
    );

    ptsd_back #(
        .CW (COORD_WIDTH),
        .F  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_pop),
        .in_req    (mid_head),
        .out_valid (back_valid),
        .out_res   (back_res)
    );

    ptsd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (back_valid),
        .push_data (back_res),
        .pop       (out_take),
        .empty     (empty),
        .head      (out_head)
    );

    assign res         = out_head;
    assign sq_distance = res.sq_distance;
    assign closest_x   = res.closest[0];
    assign closest_y   = res.closest[1];
    assign closest_z   = res.closest[2];
    assign param_s     = res.param_s;
    assign param_t     = res.param_t;
    assign region      = res.region;
    assign degenerate  = res.degenerate;

    a_mid_credit: assert property (@(posedge clk) disable iff (!rst_n)
        mid_credit_reg <= MRW'(MID_DEPTH))
        else $error("classifier credit overrun");

    a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_credit_reg <= ORW'(OUT_DEPTH))
        else $error("result credit overrun");

    a_credit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_credit_reg == '0) |-> empty)
        else $error("result queue holds data without credit");

endmodule
